// ===== src/box_octant_split_by_point_top_macros.svh =====
// assertion macros for the top-level rtl file
`ifndef BOX_OCTANT_SPLIT_BY_POINT_TOP_MACROS_SVH
`define BOX_OCTANT_SPLIT_BY_POINT_TOP_MACROS_SVH

// same-cycle implication, checked on clk with reset masked
`define BOSP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on clk with reset masked
`define BOSP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/bosp_pkg.sv =====
// ----------------------------------------------------------------------------
// bosp_pkg
// types, codes and widths shared by the box octant split blocks
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bosp_pkg;

  localparam int COORD_W    = 32;
  localparam int NUM_AXES   = 3;
  localparam int NUM_OCT    = 8;
  localparam int OCT_W      = 3;
  localparam int IN_DATA_W  = ((9 * COORD_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((OCT_W + 6 * COORD_W + 7) / 8) * 8;

  localparam logic [1:0] AX_X = 2'd0;
  localparam logic [1:0] AX_Y = 2'd1;
  localparam logic [1:0] AX_Z = 2'd2;

  typedef logic signed [COORD_W-1:0] bosp_coord_t;

  typedef enum logic [1:0] {
    ST_PIECE   = 2'd0,
    ST_OUTSIDE = 2'd1,
    ST_CORNER  = 2'd2,
    ST_EMPTY   = 2'd3
  } bosp_status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_DECIDE,
    S_EMIT
  } bosp_state_t;

  // operand select for the shared comparator
  typedef struct packed {
    logic [1:0] axis;
    logic       upper;
  } bosp_cmp_sel_t;

  typedef struct packed {
    logic lt;
    logic eq;
  } bosp_cmp_res_t;

  // result load request from the sequencer
  typedef struct packed {
    logic               load;
    bosp_status_t       status;
    logic               last;
    logic [OCT_W-1:0]   octant;
  } bosp_res_t;

endpackage

// ===== src/bosp_cmp.sv =====
// ----------------------------------------------------------------------------
// bosp_cmp
// shared signed comparator: a less than b, a equal to b
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bosp_cmp (
  input  bosp_pkg::bosp_coord_t   a,
  input  bosp_pkg::bosp_coord_t   b,
  output bosp_pkg::bosp_cmp_res_t res
);
  import bosp_pkg::*;

  always_comb begin
    res.lt = (a < b);
    res.eq = (a == b);
  end

endmodule

// ===== src/bosp_ctrl.sv =====
// ----------------------------------------------------------------------------
// bosp_ctrl
// sequencer: six compare steps, decision, then, if pieces remain, octant walk
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bosp_ctrl (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_fire,
  input  logic                    slot_free,
  input  bosp_pkg::bosp_cmp_res_t cmp_res,
  output bosp_pkg::bosp_cmp_sel_t cmp_sel,
  output logic                    in_ready,
  output bosp_pkg::bosp_res_t     res
);
  import bosp_pkg::*;

  localparam logic [2:0] LAST_STEP = 3'(2 * NUM_AXES - 1);

  bosp_state_t            state_r, state_nxt;
  logic [2:0]             step_r, step_nxt;
  logic [OCT_W-1:0]       oct_r, oct_nxt;
  logic                   outside_r, outside_nxt;
  logic [NUM_AXES-1:0]    eqmin_r, eqmin_nxt;
  logic [NUM_AXES-1:0]    eqmax_r, eqmax_nxt;

  logic [NUM_OCT-1:0]     keep;
  logic [NUM_OCT-1:0]     keep_rest;
  logic                   corner;
  logic                   oct_last;

  // an octant survives when its half has extent on every axis
  always_comb begin
    for (int i = 0; i < NUM_OCT; i++) begin
      logic up_x, up_y, up_z;
      up_z = i[0];
      up_x = i[1];
      up_y = i[2];
      keep[i] = !(up_x ? eqmax_r[AX_X] : eqmin_r[AX_X]) &&
                !(up_y ? eqmax_r[AX_Y] : eqmin_r[AX_Y]) &&
                !(up_z ? eqmax_r[AX_Z] : eqmin_r[AX_Z]);
    end
  end

  assign corner    = &(eqmin_r | eqmax_r);
  assign keep_rest = keep >> oct_r;
  assign oct_last  = (keep_rest[NUM_OCT-1:1] == '0);

  assign cmp_sel.axis  = step_r[2:1];
  assign cmp_sel.upper = step_r[0];

  // next state
  always_comb begin
    state_nxt   = state_r;
    step_nxt    = step_r;
    oct_nxt     = oct_r;
    outside_nxt = outside_r;
    eqmin_nxt   = eqmin_r;
    eqmax_nxt   = eqmax_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt   = S_CMP;
          step_nxt    = '0;
          outside_nxt = 1'b0;
        end
      end
      S_CMP: begin
        outside_nxt = outside_r | cmp_res.lt;
        if (step_r[0]) begin
          eqmax_nxt[step_r[2:1]] = cmp_res.eq;
        end else begin
          eqmin_nxt[step_r[2:1]] = cmp_res.eq;
        end
        step_nxt = step_r + 3'd1;
        if (step_r == LAST_STEP) begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (outside_r || corner || keep == '0) begin
          if (slot_free) begin
            state_nxt = S_IDLE;
          end
        end else begin
          state_nxt = S_EMIT;
          oct_nxt   = '0;
        end
      end
      S_EMIT: begin
        if (!keep[oct_r]) begin
          oct_nxt = oct_r + 1'b1;
        end else if (slot_free) begin
          oct_nxt = oct_r + 1'b1;
          if (oct_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready   = 1'b0;
    res.load   = 1'b0;
    res.status = ST_PIECE;
    res.last   = 1'b1;
    res.octant = '0;
    unique case (state_r)
      S_IDLE: in_ready = 1'b1;
      S_CMP: ;
      S_DECIDE: begin
        res.load = slot_free && (outside_r || corner || keep == '0);
        if (outside_r) begin
          res.status = ST_OUTSIDE;
        end else if (corner) begin
          res.status = ST_CORNER;
        end else begin
          res.status = ST_EMPTY;
        end
      end
      S_EMIT: begin
        res.load   = slot_free && keep[oct_r];
        res.last   = oct_last;
        res.octant = oct_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
      oct_r   <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      oct_r   <= oct_nxt;
    end
    outside_r <= outside_nxt;
    eqmin_r   <= eqmin_nxt;
    eqmax_r   <= eqmax_nxt;
  end

endmodule

// ===== src/box_octant_split_by_point_top.sv =====
// ----------------------------------------------------------------------------
// box_octant_split_by_point_top
// cuts an axis-aligned box at a point into its non-empty octant boxes
// ----------------------------------------------------------------------------
// One input transfer carries a box (lower and upper corner) and a split point,
// all signed Q16.16. A point outside the box gives one result with status
// outside, a point on a box corner one result with status corner; otherwise
// each octant with extent on all three axes comes out as one result, in
// octant code order (y half, x half, z half, low first), the final one with
// tlast set, or one result with status empty if none is left. A single
// shared signed comparator checks the point against each bound in turn, a
// decision step follows, and the octant walk then steps through the octant
// codes one per cycle, from code zero up to the last surviving octant, with
// a result stalled whenever the output register is still full. in_tready is
// high only while the block waits for a new box, and it rises as soon as
// the last result is in the output register.
`timescale 1ns / 1ps

`include "box_octant_split_by_point_top_macros.svh"

module box_octant_split_by_point_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
  // point_x, point_y, point_z
  input  logic [bosp_pkg::IN_DATA_W-1:0]   in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // octant, piece_min_x, piece_min_y, piece_min_z, piece_max_x,
  // piece_max_y, piece_max_z, zero padding
  output logic [bosp_pkg::OUT_DATA_W-1:0]  out_tdata,
  // status
  output logic [1:0]                       out_tuser,
  output logic                             out_tlast
);
  import bosp_pkg::*;

  // captured box and point, indexed by axis
  bosp_coord_t bmin_r [NUM_AXES];
  bosp_coord_t bmax_r [NUM_AXES];
  bosp_coord_t pt_r   [NUM_AXES];

  logic                  in_fire;
  logic                  slot_free;
  bosp_cmp_sel_t         cmp_sel;
  bosp_cmp_res_t         cmp_res;
  bosp_coord_t           cmp_a, cmp_b;
  bosp_res_t             res;

  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  bosp_status_t          out_status_r;
  logic                  out_last_r;

  assign in_fire   = in_tvalid && in_tready;
  assign slot_free = !out_valid_r || out_tready;

  // capture the input transfer
  always_ff @(posedge clk) begin
    if (in_fire) begin
      for (int a = 0; a < NUM_AXES; a++) begin
        bmin_r[a] <= in_tdata[a * COORD_W +: COORD_W];
        bmax_r[a] <= in_tdata[(NUM_AXES + a) * COORD_W +: COORD_W];
        pt_r[a]   <= in_tdata[(2 * NUM_AXES + a) * COORD_W +: COORD_W];
      end
    end
  end

  // lower bound step: point < min; upper bound step: max < point
  assign cmp_a = cmp_sel.upper ? bmax_r[cmp_sel.axis] : pt_r[cmp_sel.axis];
  assign cmp_b = cmp_sel.upper ? pt_r[cmp_sel.axis]   : bmin_r[cmp_sel.axis];

  bosp_cmp u_cmp (
    .a   (cmp_a),
    .b   (cmp_b),
    .res (cmp_res)
  );

  bosp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .slot_free (slot_free),
    .cmp_res   (cmp_res),
    .cmp_sel   (cmp_sel),
    .in_ready  (in_tready),
    .res       (res)
  );

  // piece bounds for the requested octant, zero for results without a piece
  always_comb begin
    logic up [NUM_AXES];
    out_data_nxt = '0;
    up[AX_X] = res.octant[1];
    up[AX_Y] = res.octant[2];
    up[AX_Z] = res.octant[0];
    if (res.status == ST_PIECE) begin
      out_data_nxt[OCT_W-1:0] = res.octant;
      for (int a = 0; a < NUM_AXES; a++) begin
        out_data_nxt[OCT_W + a * COORD_W +: COORD_W] =
          up[a] ? pt_r[a] : bmin_r[a];
        out_data_nxt[OCT_W + (NUM_AXES + a) * COORD_W +: COORD_W] =
          up[a] ? bmax_r[a] : pt_r[a];
      end
    end
  end

  // output register: loads only when empty or being drained
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res.load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
    if (res.load) begin
      out_data_r   <= out_data_nxt;
      out_status_r <= res.status;
      out_last_r   <= res.last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;

  // results without a piece carry no bounds and close the item
  `BOSP_ASSERT_NOW(a_nopiece_zero, out_tvalid && (out_tuser != ST_PIECE), (out_tdata == '0) && out_tlast, "non-piece result not zero or not last")

  // a new box is never taken while the sequencer is issuing a result
  `BOSP_ASSERT_NOW(a_no_load_in_idle, in_tready, !res.load, "result load while waiting for input")

  // a load never overwrites a result that is still waiting
  `BOSP_ASSERT_NOW(a_load_slot_free, res.load, slot_free, "output register overwritten")

  // after the final result is loaded the block waits for the next box
  `BOSP_ASSERT_NEXT(a_last_to_idle, res.load && res.last, in_tready, "no return to idle after last result")

endmodule

// ===== tb/sv/tb_box_octant_split_by_point_top.sv =====
// ----------------------------------------------------------------------------
// tb_box_octant_split_by_point_top
// self-checking bench for the box octant split block
// ----------------------------------------------------------------------------
// The bench first sends a short table of hand-picked boxes: points outside,
// on corners, on faces and edges, flat and inverted boxes, and the extremes
// of the coordinate range. It then sends random boxes of mixed shapes. For
// every box taken in, the table row or a local octant model queues its results.
// Each result transfer is compared field by field against the oldest queued
// piece. Both sides insert random gaps, and once the result side holds off
// for a long stretch so that the block backs up into its input.
`timescale 1ns / 1ps

module tb_box_octant_split_by_point_top;
  import bosp_pkg::*;

  localparam int          RANDOM_BOXES = 140;
  localparam int          HOLD_OFF     = 300;  // long result stall, in cycles
  localparam int          IDLE_LIMIT   = 2000; // well above HOLD_OFF plus slow gaps
  localparam int          DRAIN_CYCLES = 40;
  localparam int          PAD_LSB      = OCT_W + 6 * COORD_W;
  localparam bosp_coord_t CMIN         = 32'sh8000_0000;
  localparam bosp_coord_t CMAX         = 32'sh7fff_ffff;

  typedef enum int {
    SH_NORMAL,
    SH_CORNER,
    SH_OUTSIDE,
    SH_FLAT,
    SH_INVERTED,
    SH_NOISE
  } axis_shape_t;

  // axis index 0 = x, 1 = y, 2 = z
  typedef struct packed {
    bosp_coord_t [2:0] bmin;
    bosp_coord_t [2:0] bmax;
    bosp_coord_t [2:0] pt;
  } box_job_t;

  typedef struct packed {
    bosp_status_t      status;
    logic              last;
    logic [OCT_W-1:0]  octant;
    bosp_coord_t [2:0] lo;
    bosp_coord_t [2:0] hi;
  } piece_t;

  typedef struct packed {
    box_job_t     job;
    logic         typed;  // expected result given in the row itself
    bosp_status_t status;
  } box_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [1:0]            out_tuser;
  logic                  out_tlast;

  piece_t   pieces_due[$];
  box_row_t box_table[$];
  int       errors      = 0;
  int       boxes_sent  = 0;
  int       pieces_seen = 0;
  int       status_seen[4];
  int       idle_cycles = 0;
  bit       sender_burst = 1'b0;
  bit       held_off     = 1'b0;
  string    axis_name[3] = '{"x", "y", "z"};

  box_octant_split_by_point_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #5 clk = ~clk;

  // single result that carries no piece: zero octant and bounds, last set
  function automatic piece_t no_piece(input bosp_status_t st);
    piece_t p;
    p = '0;
    p.status = st;
    p.last = 1'b1;
    return p;
  endfunction

  // appends one expected result at the tail of the queue
  function automatic void expect_piece(input piece_t p);
    pieces_due.insert(pieces_due.size(), p);
  endfunction

  // queues the results one box should give
  function automatic void predict_pieces(input box_job_t j);
    piece_t     cut[$];
    piece_t     p;
    logic       corner;
    logic       keep;
    logic [2:0] up;
    corner = 1'b1;
    for (int a = 0; a < NUM_AXES; a++) begin
      if ($signed(j.pt[a]) < $signed(j.bmin[a]) || $signed(j.pt[a]) > $signed(j.bmax[a])) begin
        expect_piece(no_piece(ST_OUTSIDE));
        return;
      end
    end
    for (int a = 0; a < NUM_AXES; a++)
      if (j.pt[a] != j.bmin[a] && j.pt[a] != j.bmax[a]) corner = 1'b0;
    if (corner) begin
      expect_piece(no_piece(ST_CORNER));
      return;
    end
    for (int i = 0; i < NUM_OCT; i++) begin
      // octant code is y, x, z from the top bit down
      up = {i[0], i[2], i[1]};
      p = '0;
      p.status = ST_PIECE;
      p.octant = i[OCT_W-1:0];
      keep = 1'b1;
      for (int a = 0; a < NUM_AXES; a++) begin
        p.lo[a] = up[a] ? j.pt[a] : j.bmin[a];
        p.hi[a] = up[a] ? j.bmax[a] : j.pt[a];
        if (p.lo[a] == p.hi[a]) keep = 1'b0;
      end
      if (keep) cut.insert(cut.size(), p);
    end
    if (cut.size() == 0) begin
      expect_piece(no_piece(ST_EMPTY));
    end else begin
      foreach (cut[k]) begin
        if (k == cut.size() - 1) cut[k].last = 1'b1;
        expect_piece(cut[k]);
      end
    end
  endfunction

  function automatic void add_row(input bosp_coord_t nx, ny, nz, xx, xy, xz, px, py, pz,
                                  input logic typed, input bosp_status_t st);
    box_row_t r;
    r.job.bmin = {nz, ny, nx};
    r.job.bmax = {xz, xy, xx};
    r.job.pt   = {pz, py, px};
    r.typed    = typed;
    r.status   = st;
    box_table.insert(box_table.size(), r);
  endfunction

  // one axis of a random box, shaped so that faces and corners come up often
  function automatic void make_axis(input axis_shape_t shape,
                                    output bosp_coord_t lo, hi, pt);
    bosp_coord_t a;
    bosp_coord_t b;
    longint      span;
    longint      off;
    int          pick;
    a = $urandom;
    b = $urandom_range(0, 1) ? a + bosp_coord_t'($urandom_range(0, 8)) : bosp_coord_t'($urandom);
    if ($signed(a) <= $signed(b)) begin
      lo = a;
      hi = b;
    end else begin
      lo = b;
      hi = a;
    end
    span = longint'(hi) - longint'(lo);
    off  = longint'($urandom) % (span + 1);
    pick = $urandom_range(0, 9);
    if (pick == 0)      pt = lo;
    else if (pick == 1) pt = hi;
    else                pt = bosp_coord_t'(longint'(lo) + off);
    case (shape)
      SH_CORNER: begin
        pt = $urandom_range(0, 1) ? lo : hi;
      end
      SH_OUTSIDE: begin
        if (lo != CMIN && $urandom_range(0, 1)) pt = lo - 1;
        else if (hi != CMAX)                    pt = hi + 1;
        else                                    pt = lo - 1;
      end
      SH_FLAT: begin
        hi = lo;
        pt = lo;
      end
      SH_INVERTED: begin
        if (lo == hi) begin
          lo = hi + 1;
        end else begin
          a  = lo;
          lo = hi;
          hi = a;
        end
      end
      SH_NOISE: begin
        lo = $urandom;
        hi = $urandom;
        pt = $urandom;
      end
      default: begin
      end
    endcase
  endfunction

  // offers one box, keeps valid up across back-to-back transfers
  task automatic send_box(input box_job_t j, input logic typed, input bosp_status_t st);
    int                   gap;
    logic [IN_DATA_W-1:0] data;
    gap = sender_burst ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    data = '0;
    for (int a = 0; a < NUM_AXES; a++) begin
      data[a * COORD_W +: COORD_W]       = j.bmin[a];
      data[(3 + a) * COORD_W +: COORD_W] = j.bmax[a];
      data[(6 + a) * COORD_W +: COORD_W] = j.pt[a];
    end
    in_tvalid <= 1'b1;
    in_tdata  <= data;
    do @(posedge clk); while (in_tready !== 1'b1);
    if (typed) expect_piece(no_piece(st));
    else       predict_pieces(j);
    boxes_sent++;
  endtask

  function automatic void check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  // result side: random stalls, one long hold-off, a stretch with none
  initial begin : result_sink
    int stall;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = $urandom_range(0, 5);
      if (pieces_seen >= 200 && pieces_seen < 260) stall = 0;
      if (!held_off && pieces_seen >= 80) begin
        stall = HOLD_OFF;
        held_off = 1'b1;
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid === 1'b1 && out_tready === 1'b1));
    end
  end

  // compare every result transfer with the oldest queued piece
  always @(posedge clk) begin : result_check
    piece_t want;
    if (rst_n === 1'b1 && out_tvalid === 1'b1 && out_tready === 1'b1) begin
      pieces_seen++;
      status_seen[out_tuser]++;
      if (pieces_due.size() == 0) begin
        $error("result transfer with nothing expected, status %0d", out_tuser);
        errors++;
      end else begin
        want = pieces_due.pop_front();
        check_field("status", want.status, out_tuser);
        check_field("last", want.last, out_tlast);
        check_field("octant", want.octant, out_tdata[OCT_W-1:0]);
        for (int a = 0; a < NUM_AXES; a++) begin
          check_field({"piece_min_", axis_name[a]}, longint'($signed(want.lo[a])),
                      longint'($signed(out_tdata[OCT_W + a * COORD_W +: COORD_W])));
          check_field({"piece_max_", axis_name[a]}, longint'($signed(want.hi[a])),
                      longint'($signed(out_tdata[OCT_W + (3 + a) * COORD_W +: COORD_W])));
        end
        check_field("padding", 0, longint'(out_tdata >> PAD_LSB));
      end
    end
  end

  // cycles with no transfer on either side
  always @(posedge clk) begin : watchdog
    if (idle_cycles == IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else if ((in_tvalid === 1'b1 && in_tready === 1'b1) ||
                 (out_tvalid === 1'b1 && out_tready === 1'b1)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    box_job_t    job;
    bosp_coord_t lo;
    bosp_coord_t hi;
    bosp_coord_t p;
    axis_shape_t shape;
    int          k;
    int          odd;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    status_seen = '{0, 0, 0, 0};

    // point outside on each side, then at the range extremes
    add_row(0, 0, 0, 10, 10, 10, -1, 5, 5, 1'b1, ST_OUTSIDE);
    add_row(0, 0, 0, 10, 10, 10, 5, 11, 5, 1'b1, ST_OUTSIDE);
    add_row(0, 0, 0, 10, 10, 10, 5, 5, CMIN, 1'b1, ST_OUTSIDE);
    add_row(0, 0, 0, 10, 10, 10, CMAX, 5, 5, 1'b1, ST_OUTSIDE);
    // inverted box contains nothing
    add_row(10, 0, 0, 0, 10, 10, 5, 5, 5, 1'b1, ST_OUTSIDE);
    // corners: lower, upper, mixed
    add_row(0, 0, 0, 10, 10, 10, 0, 0, 0, 1'b1, ST_CORNER);
    add_row(0, 0, 0, 10, 10, 10, 10, 10, 10, 1'b1, ST_CORNER);
    add_row(0, 0, 0, 10, 10, 10, 0, 10, 0, 1'b1, ST_CORNER);
    // flat box with the point off its corners leaves nothing
    add_row(0, 0, 5, 10, 10, 5, 3, 4, 5, 1'b1, ST_EMPTY);
    // box shrunk to a single point, then flat boxes with the point outside or on a corner
    add_row(7, 7, 7, 7, 7, 7, 7, 7, 7, 1'b1, ST_CORNER);
    add_row(2, 0, 0, 2, 10, 10, 2, 20, 5, 1'b1, ST_OUTSIDE);
    add_row(0, 3, 0, 10, 3, 10, 10, 3, 0, 1'b1, ST_CORNER);
    // full coordinate range
    add_row(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, 0, 0, 0, 1'b0, ST_PIECE);
    add_row(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, CMIN, CMAX, CMIN, 1'b1, ST_CORNER);
    add_row(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, CMAX, 0, CMIN, 1'b0, ST_PIECE);
    // point on a face, on an edge, strictly inside, then on a face again
    add_row(0, 0, 0, 10, 10, 10, 0, 5, 5, 1'b0, ST_PIECE);
    add_row(0, 0, 0, 10, 10, 10, 0, 10, 5, 1'b0, ST_PIECE);
    add_row(-100, -200, -300, -1, 50, 7, -40, 0, -299, 1'b0, ST_PIECE);
    add_row(0, 0, 0, 2, 2, 2, 1, 1, 1, 1'b0, ST_PIECE);
    add_row(32'sh0001_0000, -32'sh0002_8000, 0, 32'sh0003_0000, 32'sh0000_4000, 1,
            32'sh0002_0000, 0, 1, 1'b0, ST_PIECE);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    foreach (box_table[r])
      send_box(box_table[r].job, box_table[r].typed, box_table[r].status);

    // mostly well-formed boxes, with corner, outside, flat, inverted and noise mixed in
    for (int n = 0; n < RANDOM_BOXES; n++) begin
      sender_burst = (n >= 60 && n < 90);
      k   = $urandom_range(0, 99);
      odd = $urandom_range(0, 2);
      for (int a = 0; a < NUM_AXES; a++) begin
        if (k < 55)         shape = SH_NORMAL;
        else if (k < 65)    shape = SH_CORNER;
        else if (k >= 92)   shape = SH_NOISE;
        else if (a != odd)  shape = SH_NORMAL;
        else if (k < 75)    shape = SH_OUTSIDE;
        else if (k < 85)    shape = SH_FLAT;
        else                shape = SH_INVERTED;
        make_axis(shape, lo, hi, p);
        job.bmin[a] = lo;
        job.bmax[a] = hi;
        job.pt[a]   = p;
      end
      send_box(job, 1'b0, ST_PIECE);
    end
    in_tvalid <= 1'b0;

    while (pieces_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d boxes split (%0d from the table), %0d results compared",
             boxes_sent, box_table.size(), pieces_seen);
    $display("results: %0d pieces, %0d outside, %0d on a corner, %0d empty",
             status_seen[ST_PIECE], status_seen[ST_OUTSIDE],
             status_seen[ST_CORNER], status_seen[ST_EMPTY]);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
